### hw/rtl/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types and constants of the character LCD nibble writer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

    // Command codes carried on the input tuser
    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_RAW    = 3'd1,
        CMD_CHAR   = 3'd2,
        CMD_SETPOS = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_RIGHT  = 3'd5,
        CMD_LEFT   = 3'd6,
        CMD_DELETE = 3'd7
    } cmd_t;

    localparam int MAX_BYTES = 6;
    localparam int BYTE_IDX_W = $clog2(MAX_BYTES);
    localparam int NBYTES_W = $clog2(MAX_BYTES + 1);
    localparam int NIB_IDX_W = $clog2(2 * MAX_BYTES);

    localparam logic [7:0] LCD_INIT_A    = 8'h33;
    localparam logic [7:0] LCD_INIT_B    = 8'h32;
    localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0F;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] LCD_CLEAR     = 8'h01;
    localparam logic [7:0] LCD_SHIFT_R   = 8'h14;
    localparam logic [7:0] LCD_SHIFT_L   = 8'h10;
    localparam logic [7:0] LCD_ROW0_HOME = 8'h80;
    localparam logic [7:0] LCD_ROW1_HOME = 8'hC0;
    localparam logic [7:0] LCD_ROW0_END  = 8'h8F;
    localparam logic [7:0] LCD_ROW1_END  = 8'hCF;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_MIN      = 8'd32;
    localparam logic [7:0] CHAR_MAX      = 8'd125;
    localparam logic [4:0] POS_ROW0_END  = 5'd15;
    localparam logic [4:0] POS_ROW1_HOME = 5'd16;
    localparam logic [4:0] POS_LAST      = 5'd31;

    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // One queued item: the byte run of a command and the final cursor
    typedef struct packed {
        logic [NBYTES_W-1:0]            nbytes;
        logic [MAX_BYTES-1:0][7:0]      bytes;
        logic [MAX_BYTES-1:0]           rs;
        logic [4:0]                     cursor;
    } entry_t;

endpackage

### hw/rtl/lcdnw_front.sv
// ----------------------------------------------------------------------------
// lcdnw_front
// Accepts commands, tracks the cursor and expands each command into a byte run.
// ----------------------------------------------------------------------------
module lcdnw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lcdnw_pkg::cmd_t      cmd,
    input  logic [7:0]           data_byte,
    input  logic                 row,
    input  logic [5:0]           col,
    input  logic                 q_full,
    output logic                 q_push,
    output lcdnw_pkg::entry_t    q_entry
);
    import lcdnw_pkg::*;

    typedef struct packed {
        logic [4:0] pos;
        logic       emit;
        logic [7:0] code;
    } step_t;

    logic [4:0] cursor_reg;
    logic [4:0] cursor_next;
    logic       accept;

    function automatic step_t step_right(input logic [4:0] p);
        step_t r;
        r.pos  = p + 5'd1;
        r.emit = 1'b0;
        r.code = LCD_ROW0_HOME;
        if (p == POS_ROW0_END)
        begin
            r.emit = 1'b1;
            r.code = LCD_ROW1_HOME;
        end
        else if (p == POS_LAST)
        begin
            r.emit = 1'b1;
            r.code = LCD_ROW0_HOME;
        end
        return r;
    endfunction

    function automatic step_t step_left(input logic [4:0] p);
        step_t r;
        r.pos  = p - 5'd1;
        r.emit = 1'b0;
        r.code = LCD_ROW0_END;
        if (p == POS_ROW1_HOME)
        begin
            r.emit = 1'b1;
            r.code = LCD_ROW0_END;
        end
        else if (p == 5'd0)
        begin
            r.emit = 1'b1;
            r.code = LCD_ROW1_END;
        end
        return r;
    endfunction

    always_comb
    begin
        logic [MAX_BYTES-1:0][7:0] bl;
        logic [MAX_BYTES-1:0]      rl;
        logic [BYTE_IDX_W-1:0]     cnt;
        logic [4:0]                pos;
        step_t                     st;
        bl  = '0;
        rl  = '0;
        cnt = '0;
        pos = cursor_reg;
        st  = '0;
        unique case (cmd)
            CMD_INIT:
            begin
                bl[0] = LCD_INIT_A;
                bl[1] = LCD_INIT_B;
                bl[2] = LCD_FUNC_SET;
                bl[3] = LCD_DISP_ON;
                bl[4] = LCD_ENTRY;
                bl[5] = LCD_CLEAR;
                cnt = BYTE_IDX_W'(6);
                pos = 5'd0;
            end
            CMD_RAW:
            begin
                bl[0] = data_byte;
                cnt = BYTE_IDX_W'(1);
            end
            CMD_CHAR:
            begin
                if (data_byte >= CHAR_MIN && data_byte <= CHAR_MAX)
                begin
                    bl[cnt] = data_byte;
                    rl[cnt] = RS_DATA;
                    cnt = cnt + 1'b1;
                    st = step_right(pos);
                    pos = st.pos;
                    if (st.emit)
                    begin
                        bl[cnt] = st.code;
                        cnt = cnt + 1'b1;
                    end
                end
            end
            CMD_SETPOS:
            begin
                // row * 0x40 + col never exceeds seven bits
                bl[0] = {1'b1, row, col};
                cnt = BYTE_IDX_W'(1);
                if (col <= 6'd15)
                    pos = {row, col[3:0]};
            end
            CMD_CLEAR:
            begin
                bl[0] = LCD_CLEAR;
                cnt = BYTE_IDX_W'(1);
                pos = 5'd0;
            end
            CMD_RIGHT:
            begin
                if (pos != POS_LAST)
                begin
                    bl[cnt] = LCD_SHIFT_R;
                    cnt = cnt + 1'b1;
                    st = step_right(pos);
                    pos = st.pos;
                    if (st.emit)
                    begin
                        bl[cnt] = st.code;
                        cnt = cnt + 1'b1;
                    end
                end
            end
            CMD_LEFT:
            begin
                bl[cnt] = LCD_SHIFT_L;
                cnt = cnt + 1'b1;
                st = step_left(pos);
                pos = st.pos;
                if (st.emit)
                begin
                    bl[cnt] = st.code;
                    cnt = cnt + 1'b1;
                end
            end
            CMD_DELETE:
            begin
                // back up, overwrite with a space, back up again
                bl[cnt] = LCD_SHIFT_L;
                cnt = cnt + 1'b1;
                st = step_left(pos);
                pos = st.pos;
                if (st.emit)
                begin
                    bl[cnt] = st.code;
                    cnt = cnt + 1'b1;
                end
                bl[cnt] = CHAR_SPACE;
                rl[cnt] = RS_DATA;
                cnt = cnt + 1'b1;
                st = step_right(pos);
                pos = st.pos;
                if (st.emit)
                begin
                    bl[cnt] = st.code;
                    cnt = cnt + 1'b1;
                end
                bl[cnt] = LCD_SHIFT_L;
                cnt = cnt + 1'b1;
                st = step_left(pos);
                pos = st.pos;
                if (st.emit)
                begin
                    bl[cnt] = st.code;
                    cnt = cnt + 1'b1;
                end
            end
            default:
            begin
                cnt = '0;
            end
        endcase
        q_entry.nbytes = NBYTES_W'(cnt);
        q_entry.bytes  = bl;
        q_entry.rs     = rl;
        q_entry.cursor = pos;
        cursor_next    = pos;
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    // drop commands that produce no writes
    assign q_push   = accept && (q_entry.nbytes != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cursor_reg <= 5'd0;
        else if (accept)
            cursor_reg <= cursor_next;
    end

    a_push_len: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_entry.nbytes <= NBYTES_W'(MAX_BYTES)))
        else $error("byte run longer than the queue entry");

    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(cursor_reg))
        else $error("cursor moved without an accepted item");

endmodule

### hw/rtl/lcdnw_queue.sv
// ----------------------------------------------------------------------------
// lcdnw_queue
// Two-entry queue of byte runs between the command front and the nibble back.
// ----------------------------------------------------------------------------
module lcdnw_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lcdnw_pkg::entry_t    push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output lcdnw_pkg::entry_t    head_entry
);
    import lcdnw_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

### hw/rtl/lcdnw_back.sv
// ----------------------------------------------------------------------------
// lcdnw_back
// Splits each queued byte run into nibble writes, high nibble first.
// ----------------------------------------------------------------------------
module lcdnw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  lcdnw_pkg::entry_t    head_entry,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 reg_select,
    output logic [3:0]           nibble,
    output logic                 last,
    output logic [4:0]           cursor_now
);
    import lcdnw_pkg::*;

    logic [NIB_IDX_W-1:0] idx_reg;
    logic                 valid_reg;
    logic                 rs_reg;
    logic [3:0]           nibble_reg;
    logic                 last_reg;
    logic [4:0]           cursor_reg;
    logic                 advance;
    logic                 load;
    logic                 at_end;
    logic [7:0]           cur_byte;

    assign advance  = !valid_reg || out_ready;
    assign load     = advance && head_valid;
    assign cur_byte = head_entry.bytes[idx_reg[NIB_IDX_W-1:1]];
    assign at_end   = (idx_reg == NIB_IDX_W'({head_entry.nbytes, 1'b0} - 1'b1));
    assign pop      = load && at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= head_valid;
            if (head_valid)
                idx_reg <= at_end ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rs_reg     <= head_entry.rs[idx_reg[NIB_IDX_W-1:1]];
            nibble_reg <= idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
            last_reg   <= at_end;
            cursor_reg <= head_entry.cursor;
        end
    end

    assign out_valid  = valid_reg;
    assign reg_select = rs_reg;
    assign nibble     = nibble_reg;
    assign last       = last_reg;
    assign cursor_now = cursor_reg;

    a_mid_run_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> head_valid)
        else $error("byte run left the queue before its last nibble");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < NIB_IDX_W'({head_entry.nbytes, 1'b0})))
        else $error("nibble index past the end of the run");

endmodule

### hw/rtl/char_lcd_nibble_writer_with_cursor_core.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_with_cursor_core
// 4-bit character LCD writer: commands in, register-select/nibble writes out.
//
//  port group | dir | item content
//  -----------+-----+--------------------------------------------------------
//  s_axis     | in  | command: tuser cmd, tdata data_byte/row/col
//  m_axis     | out | nibble write: tuser reg_select, tlast, tdata nibble/cursor
//
//  One nibble write leaves per cycle while a run is queued and m_axis_tready
//  is high; k bytes give 2k writes (2 to 12) via the back end nibble counter.
//  A command is taken every cycle while the two-entry queue has room;
//  commands that produce no write are taken but reach no queue entry.
//  Reset clears the cursor to 0, empties the queue and drops the output.
//  m_axis_tready low holds the output register; the queue then fills and
//  s_axis_tready falls.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_with_cursor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [8] row, [14:9] col
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] nibble, [8:4] cursor_now
    output logic        m_axis_tuser,   // [0] reg_select
    output logic        m_axis_tlast
);
    import lcdnw_pkg::*;

    entry_t     push_entry;
    entry_t     head_entry;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       head_valid;
    logic [3:0] nibble;
    logic [4:0] cursor_now;

    lcdnw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cmd       (cmd_t'(s_axis_tuser)),
        .data_byte (s_axis_tdata[7:0]),
        .row       (s_axis_tdata[8]),
        .col       (s_axis_tdata[14:9]),
        .q_full    (q_full),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    lcdnw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    lcdnw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .reg_select (m_axis_tuser),
        .nibble     (nibble),
        .last       (m_axis_tlast),
        .cursor_now (cursor_now)
    );

    assign m_axis_tdata = {7'd0, cursor_now, nibble};

endmodule
